>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define LPC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define LPC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`LPC_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

>>> hw/rtl/lpc_pkg.sv
// Package with the constants and tables of the polar to cartesian converter
package lpc_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int RANGE_BITS_DEF = 18;
	localparam int ITERS          = 30;
	localparam int Z_W            = 32;
	localparam int RES_BITS       = 30;
	localparam int GAIN_W         = 30;
	localparam int GUARD_BITS     = 32;
	localparam int DATA_W_DEF     = RANGE_BITS_DEF + GUARD_BITS;

	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

	localparam logic signed [Z_W-1:0] ATAN_TAB [ITERS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage

>>> hw/rtl/lpc_if.sv
// Stream interfaces for scan points and cartesian results
interface lpc_point_if #(
	parameter int ANGLE_BITS = 16,
	parameter int RANGE_BITS = 18
);
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] angle_turn;
	logic [RANGE_BITS-1:0] range_qmm;
	logic [7:0]            signal_quality;

	modport source (output valid, angle_turn, range_qmm, signal_quality, input ready);
	modport sink (input valid, angle_turn, range_qmm, signal_quality, output ready);
endinterface

interface lpc_xy_if #(
	parameter int RANGE_BITS = 18
);
	logic                      valid;
	logic                      ready;
	logic signed [RANGE_BITS:0] x_qmm;
	logic signed [RANGE_BITS:0] y_qmm;

	modport source (output valid, x_qmm, y_qmm, input ready);
	modport sink (input valid, x_qmm, y_qmm, output ready);
endinterface

>>> hw/rtl/lidar_polar_to_cartesian.sv
// Top level of the scan point polar to cartesian converter
//
//   port    dir   transaction
//   scan    sink  angle_turn, range_qmm, signal_quality
//   coord   src   x_qmm = range*sin, y_qmm = range*cos
//   cfg_wr  in    quality_filter_enable
//
// One point per cycle while coord is ready; stages: gain multiply, 30 CORDIC cells, output.
// Each cell holds one point and hands it on; ready ripples back through the cells,
// so a stalled result leaves earlier empty cells free to fill.
// Reset clears all stage valids; the filter enable resets to 1.
// Points dropped by the filter occupy no cell.
`include "assert_macros.svh"

module lidar_polar_to_cartesian import lpc_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	lpc_point_if.sink scan,
	lpc_xy_if.source  coord
);

	localparam int DATA_W = RANGE_BITS + GUARD_BITS;
	localparam logic signed [RANGE_BITS:0] OUT_MIN = {1'b1, {RANGE_BITS{1'b0}}};

	logic                     filter_q;
	logic                     valid_c [ITERS+1];
	logic                     ready_c [ITERS+1];
	logic signed [DATA_W-1:0] x_c     [ITERS+1];
	logic signed [DATA_W-1:0] y_c     [ITERS+1];
	logic signed [Z_W-1:0]    z_c     [ITERS+1];
	logic [1:0]               quad_c  [ITERS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 1'b1;
		end else if (cfg_wr_en) begin
			filter_q <= cfg_wr_data;
		end
	end

	lpc_prescale #(
		.ANGLE_BITS (ANGLE_BITS),
		.RANGE_BITS (RANGE_BITS),
		.DATA_W     (DATA_W)
	) u_prescale (
		.clk        (clk),
		.arst_n     (arst_n),
		.filter_en  (filter_q),
		.up_valid   (scan.valid),
		.up_ready   (scan.ready),
		.up_angle   (scan.angle_turn),
		.up_range   (scan.range_qmm),
		.up_quality (scan.signal_quality),
		.dn_valid   (valid_c[0]),
		.dn_ready   (ready_c[0]),
		.dn_x       (x_c[0]),
		.dn_z       (z_c[0]),
		.dn_quad    (quad_c[0])
	);

	assign y_c[0] = '0;

	for (genvar i = 0; i < ITERS; i++) begin : g_cell
		lpc_cordic_cell #(
			.DATA_W (DATA_W),
			.IDX    (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_x     (x_c[i]),
			.up_y     (y_c[i]),
			.up_z     (z_c[i]),
			.up_quad  (quad_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_x     (x_c[i+1]),
			.dn_y     (y_c[i+1]),
			.dn_z     (z_c[i+1]),
			.dn_quad  (quad_c[i+1])
		);
	end

	lpc_round_out #(
		.RANGE_BITS (RANGE_BITS),
		.DATA_W     (DATA_W)
	) u_round_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[ITERS]),
		.up_ready (ready_c[ITERS]),
		.up_x     (x_c[ITERS]),
		.up_y     (y_c[ITERS]),
		.up_quad  (quad_c[ITERS]),
		.coord    (coord)
	);

	`LPC_ASSERT(a_ready_through, clk, arst_n, coord.ready |-> scan.ready, "scan stalled while output drains")
	`LPC_ASSERT(a_drop_point, clk, arst_n, (scan.valid && scan.ready && filter_q && scan.signal_quality == 8'd0) |=> !valid_c[0], "filtered point entered the chain")
	`LPC_ASSERT_NEVER(a_x_sat, clk, arst_n, coord.valid && (coord.x_qmm == OUT_MIN || coord.y_qmm == OUT_MIN), "result beyond saturation limit")

endmodule

>>> hw/rtl/lpc_prescale.sv
// Entry stage: quality filter, range times CORDIC gain, quadrant split
module lpc_prescale import lpc_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int RANGE_BITS = RANGE_BITS_DEF,
	parameter int DATA_W     = DATA_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     filter_en,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  logic [ANGLE_BITS-1:0]    up_angle,
	input  logic [RANGE_BITS-1:0]    up_range,
	input  logic [7:0]               up_quality,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output logic signed [DATA_W-1:0] dn_x,
	output logic signed [Z_W-1:0]    dn_z,
	output logic [1:0]               dn_quad
);

	localparam int PROD_W = RANGE_BITS + GAIN_W;

	logic                     valid_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [Z_W-1:0]    z_q;
	logic [1:0]               quad_q;
	logic [PROD_W-1:0]        prod;
	logic [RES_BITS-1:0]      residual;
	logic                     keep;

	assign up_ready = !valid_q || dn_ready;
	assign keep     = !(filter_en && up_quality == 8'd0);
	assign prod     = PROD_W'(up_range) * PROD_W'(GAIN_Q30);
	assign residual = {up_angle[ANGLE_BITS-3:0], {(Z_W-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			x_q    <= DATA_W'(prod);
			z_q    <= Z_W'(residual);
			quad_q <= up_angle[ANGLE_BITS-1:ANGLE_BITS-2];
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_z     = z_q;
	assign dn_quad  = quad_q;

endmodule

>>> hw/rtl/lpc_cordic_cell.sv
// One CORDIC rotation cell with its own stage register
module lpc_cordic_cell import lpc_pkg::*; #(
	parameter int DATA_W = DATA_W_DEF,
	parameter int IDX    = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  logic signed [DATA_W-1:0] up_x,
	input  logic signed [DATA_W-1:0] up_y,
	input  logic signed [Z_W-1:0]    up_z,
	input  logic [1:0]               up_quad,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output logic signed [DATA_W-1:0] dn_x,
	output logic signed [DATA_W-1:0] dn_y,
	output logic signed [Z_W-1:0]    dn_z,
	output logic [1:0]               dn_quad
);

	localparam logic signed [Z_W-1:0] ANGLE_STEP = ATAN_TAB[IDX];

	logic                     valid_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [1:0]               quad_q;
	logic signed [DATA_W-1:0] x_sh;
	logic signed [DATA_W-1:0] y_sh;

	assign up_ready = !valid_q || dn_ready;
	assign x_sh     = up_x >>> IDX;
	assign y_sh     = up_y >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			quad_q <= up_quad;
			if (!up_z[Z_W-1]) begin
				x_q <= up_x - y_sh;
				y_q <= up_y + x_sh;
				z_q <= up_z - ANGLE_STEP;
			end else begin
				x_q <= up_x + y_sh;
				y_q <= up_y - x_sh;
				z_q <= up_z + ANGLE_STEP;
			end
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;
	assign dn_quad  = quad_q;

endmodule

>>> hw/rtl/lpc_round_out.sv
// Output stage: quadrant mapping, rounding, saturation and result register
module lpc_round_out import lpc_pkg::*; #(
	parameter int RANGE_BITS = RANGE_BITS_DEF,
	parameter int DATA_W     = DATA_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  logic signed [DATA_W-1:0] up_x,
	input  logic signed [DATA_W-1:0] up_y,
	input  logic [1:0]               up_quad,
	lpc_xy_if.source                 coord
);

	localparam logic signed [DATA_W:0] LIM  = (DATA_W+1)'((64'd1 << RANGE_BITS) - 64'd1);
	localparam logic signed [DATA_W:0] HALF = (DATA_W+1)'(64'd1 << (RES_BITS - 1));

	logic                       valid_q;
	logic signed [RANGE_BITS:0] x_q;
	logic signed [RANGE_BITS:0] y_q;
	logic signed [DATA_W-1:0]   sin_v;
	logic signed [DATA_W-1:0]   cos_v;

	function automatic logic signed [RANGE_BITS:0] rnd(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W:0] sum;
		logic signed [DATA_W:0] sh;
		sum = {v[DATA_W-1], v} + HALF;
		sh  = sum >>> RES_BITS;
		if (sh > LIM) begin
			sh = LIM;
		end else if (sh < -LIM) begin
			sh = -LIM;
		end
		return sh[RANGE_BITS:0];
	endfunction

	always_comb begin
		case (up_quad)
			2'd0: begin
				sin_v = up_y;
				cos_v = up_x;
			end
			2'd1: begin
				sin_v = up_x;
				cos_v = -up_y;
			end
			2'd2: begin
				sin_v = -up_y;
				cos_v = -up_x;
			end
			default: begin
				sin_v = -up_x;
				cos_v = up_y;
			end
		endcase
	end

	assign up_ready = !valid_q || coord.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			x_q <= rnd(sin_v);
			y_q <= rnd(cos_v);
		end
	end

	assign coord.valid = valid_q;
	assign coord.x_qmm = x_q;
	assign coord.y_qmm = y_q;

endmodule
